### src/r2y_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2y_pkg
// Shared types and register indexes for the RGB to YCbCr converter.
// ----------------------------------------------------------------------------
package r2y_pkg;

  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_STANDARD_SELECT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEN_BIT_OUTPUT  = 4'd1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [9:0] luma;
    logic [9:0] chroma_blue;
    logic [9:0] chroma_red;
  } result_t;

  // Conversion mode, shared by every stage.
  typedef struct packed {
    logic standard_select;  // 0: BT.601, 1: BT.709
    logic ten_bit_output;   // 0: max 255, 1: max 1023
  } mode_t;

endpackage

### src/rgb_to_ycbcr_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_ycbcr_converter_core
// Full-range RGB to YCbCr, BT.601 or BT.709, 8-bit or 10-bit output.
// ----------------------------------------------------------------------------
// One pixel item per clock. busy is registered: high during reset and until
// the first edge that samples rst_n high, and low otherwise, so an item may
// be offered on every clock. The result appears on out_result for one cycle
// with out_strobe high, once the item has passed the input capture,
// multiply, sum and clamp registers; the receiver cannot stall and nothing
// in the pipe ever waits. The four register stages are:
// input capture, coefficient multiply (nine products), sum with chroma
// offset, and clamp/round into the output register. Coefficients are folded
// constants rounded to COEF_FRAC_BITS fraction bits, picked by mode from a
// four-entry table. Configuration writes are always taken (cfg_ready stays
// high); only bit 0 of the data is kept and unknown indexes are ignored.
// Change the mode only while no items are in flight.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr_converter_core #(
  parameter int COEF_FRAC_BITS = 22
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // pixel in
  input  logic                            start,
  output logic                            busy,
  input  r2y_pkg::pixel_t                 in_pixel,
  // result out
  output logic                            out_strobe,
  output r2y_pkg::result_t                out_result,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [r2y_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic                            cfg_data
);
  import r2y_pkg::*;

  localparam int SW = COEF_FRAC_BITS + 12;
  localparam int PW = COEF_FRAC_BITS + 10;

  logic    busy_r;
  mode_t   mode_r, mode_nxt;
  logic    s0_valid_r;
  pixel_t  s0_pixel_r;

  logic                 s1_valid;
  logic [PW-1:0]        prod_y  [3];
  logic [PW-1:0]        prod_cb [3];
  logic [PW-1:0]        prod_cr [3];
  logic                 s2_valid;
  logic signed [SW-1:0] sum_y, sum_cb, sum_cr;

  // mode registers
  always_comb begin
    mode_nxt = mode_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STANDARD_SELECT: mode_nxt.standard_select = cfg_data;
        CFG_TEN_BIT_OUTPUT:  mode_nxt.ten_bit_output  = cfg_data;
        default:             mode_nxt = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= '{standard_select: 1'b1, ten_bit_output: 1'b1};
      busy_r     <= 1'b1;
      s0_valid_r <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      busy_r     <= 1'b0;
      s0_valid_r <= start && !busy_r;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    s0_pixel_r <= in_pixel;
  end

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  r2y_mult #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_valid_r),
    .in_pixel  (s0_pixel_r),
    .mode      (mode_r),
    .out_valid (s1_valid),
    .prod_y    (prod_y),
    .prod_cb   (prod_cb),
    .prod_cr   (prod_cr)
  );

  r2y_sum #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .prod_y    (prod_y),
    .prod_cb   (prod_cb),
    .prod_cr   (prod_cr),
    .mode      (mode_r),
    .out_valid (s2_valid),
    .sum_y     (sum_y),
    .sum_cb    (sum_cb),
    .sum_cr    (sum_cr)
  );

  r2y_clamp #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_clamp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s2_valid),
    .sum_y      (sum_y),
    .sum_cb     (sum_cb),
    .sum_cr     (sum_cr),
    .mode       (mode_r),
    .out_valid  (out_strobe),
    .out_result (out_result)
  );

endmodule

### src/r2y_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2y_mult
// Coefficient selection and the nine channel products, registered.
// ----------------------------------------------------------------------------
module r2y_mult #(
  parameter int COEF_FRAC_BITS = 22
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  r2y_pkg::pixel_t               in_pixel,
  input  r2y_pkg::mode_t                mode,
  output logic                          out_valid,
  output logic [COEF_FRAC_BITS+9:0]     prod_y  [3],
  output logic [COEF_FRAC_BITS+9:0]     prod_cb [3],
  output logic [COEF_FRAC_BITS+9:0]     prod_cr [3]
);
  import r2y_pkg::*;

  localparam int S  = COEF_FRAC_BITS;
  localparam int CW = S + 2;
  localparam int PW = CW + 8;

  // Mode index: {standard_select, ten_bit_output}
  localparam logic [63:0] W  = 64'd10000;
  localparam logic [63:0] CM = 64'd255;
  localparam logic [63:0] KR [4] = '{64'd2990, 64'd2990, 64'd2126, 64'd2126};
  localparam logic [63:0] KB [4] = '{64'd1140, 64'd1140, 64'd722, 64'd722};
  localparam logic [63:0] KG [4] = '{64'd5870, 64'd5870, 64'd7152, 64'd7152};
  localparam logic [63:0] FM [4] = '{64'd255, 64'd1023, 64'd255, 64'd1023};
  localparam logic [63:0] DY = W * CM;
  localparam logic [63:0] DH = 64'd2 * CM;
  localparam logic [63:0] DCB [4] = '{64'd2 * (W - KB[0]) * CM, 64'd2 * (W - KB[1]) * CM,
                                      64'd2 * (W - KB[2]) * CM, 64'd2 * (W - KB[3]) * CM};
  localparam logic [63:0] DCR [4] = '{64'd2 * (W - KR[0]) * CM, 64'd2 * (W - KR[1]) * CM,
                                      64'd2 * (W - KR[2]) * CM, 64'd2 * (W - KR[3]) * CM};

  // numerator of round-half-up of num * 2^S / den
  function automatic logic [63:0] rnum(logic [63:0] num, logic [63:0] den);
    rnum = (num << (S + 1)) + den;
  endfunction

  localparam logic [63:0] CY_R [4] = '{
    rnum(KR[0] * FM[0], DY) / (64'd2 * DY), rnum(KR[1] * FM[1], DY) / (64'd2 * DY),
    rnum(KR[2] * FM[2], DY) / (64'd2 * DY), rnum(KR[3] * FM[3], DY) / (64'd2 * DY)};
  localparam logic [63:0] CY_G [4] = '{
    rnum(KG[0] * FM[0], DY) / (64'd2 * DY), rnum(KG[1] * FM[1], DY) / (64'd2 * DY),
    rnum(KG[2] * FM[2], DY) / (64'd2 * DY), rnum(KG[3] * FM[3], DY) / (64'd2 * DY)};
  localparam logic [63:0] CY_B [4] = '{
    rnum(KB[0] * FM[0], DY) / (64'd2 * DY), rnum(KB[1] * FM[1], DY) / (64'd2 * DY),
    rnum(KB[2] * FM[2], DY) / (64'd2 * DY), rnum(KB[3] * FM[3], DY) / (64'd2 * DY)};
  localparam logic [63:0] CH [4] = '{
    rnum(FM[0], DH) / (64'd2 * DH), rnum(FM[1], DH) / (64'd2 * DH),
    rnum(FM[2], DH) / (64'd2 * DH), rnum(FM[3], DH) / (64'd2 * DH)};
  localparam logic [63:0] CCB_R [4] = '{
    rnum(KR[0] * FM[0], DCB[0]) / (64'd2 * DCB[0]),
    rnum(KR[1] * FM[1], DCB[1]) / (64'd2 * DCB[1]),
    rnum(KR[2] * FM[2], DCB[2]) / (64'd2 * DCB[2]),
    rnum(KR[3] * FM[3], DCB[3]) / (64'd2 * DCB[3])};
  localparam logic [63:0] CCB_G [4] = '{
    rnum(KG[0] * FM[0], DCB[0]) / (64'd2 * DCB[0]),
    rnum(KG[1] * FM[1], DCB[1]) / (64'd2 * DCB[1]),
    rnum(KG[2] * FM[2], DCB[2]) / (64'd2 * DCB[2]),
    rnum(KG[3] * FM[3], DCB[3]) / (64'd2 * DCB[3])};
  localparam logic [63:0] CCR_G [4] = '{
    rnum(KG[0] * FM[0], DCR[0]) / (64'd2 * DCR[0]),
    rnum(KG[1] * FM[1], DCR[1]) / (64'd2 * DCR[1]),
    rnum(KG[2] * FM[2], DCR[2]) / (64'd2 * DCR[2]),
    rnum(KG[3] * FM[3], DCR[3]) / (64'd2 * DCR[3])};
  localparam logic [63:0] CCR_B [4] = '{
    rnum(KB[0] * FM[0], DCR[0]) / (64'd2 * DCR[0]),
    rnum(KB[1] * FM[1], DCR[1]) / (64'd2 * DCR[1]),
    rnum(KB[2] * FM[2], DCR[2]) / (64'd2 * DCR[2]),
    rnum(KB[3] * FM[3], DCR[3]) / (64'd2 * DCR[3])};

  logic [1:0]    mode_idx;
  logic [CW-1:0] c_yr, c_yg, c_yb, c_h, c_cbr, c_cbg, c_crg, c_crb;
  logic [PW-1:0] r_ext, g_ext, b_ext;
  logic          valid_r;
  logic [PW-1:0] prod_y_r  [3];
  logic [PW-1:0] prod_cb_r [3];
  logic [PW-1:0] prod_cr_r [3];
  logic [PW-1:0] prod_y_nxt  [3];
  logic [PW-1:0] prod_cb_nxt [3];
  logic [PW-1:0] prod_cr_nxt [3];

  assign mode_idx = {mode.standard_select, mode.ten_bit_output};

  always_comb begin
    c_yr  = CY_R[mode_idx][CW-1:0];
    c_yg  = CY_G[mode_idx][CW-1:0];
    c_yb  = CY_B[mode_idx][CW-1:0];
    c_h   = CH[mode_idx][CW-1:0];
    c_cbr = CCB_R[mode_idx][CW-1:0];
    c_cbg = CCB_G[mode_idx][CW-1:0];
    c_crg = CCR_G[mode_idx][CW-1:0];
    c_crb = CCR_B[mode_idx][CW-1:0];
    r_ext = PW'(in_pixel.red);
    g_ext = PW'(in_pixel.green);
    b_ext = PW'(in_pixel.blue);
    prod_y_nxt[0]  = PW'(c_yr) * r_ext;
    prod_y_nxt[1]  = PW'(c_yg) * g_ext;
    prod_y_nxt[2]  = PW'(c_yb) * b_ext;
    prod_cb_nxt[0] = PW'(c_h) * b_ext;
    prod_cb_nxt[1] = PW'(c_cbr) * r_ext;
    prod_cb_nxt[2] = PW'(c_cbg) * g_ext;
    prod_cr_nxt[0] = PW'(c_h) * r_ext;
    prod_cr_nxt[1] = PW'(c_crg) * g_ext;
    prod_cr_nxt[2] = PW'(c_crb) * b_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_y_r  <= prod_y_nxt;
    prod_cb_r <= prod_cb_nxt;
    prod_cr_r <= prod_cr_nxt;
  end

  assign out_valid = valid_r;
  assign prod_y    = prod_y_r;
  assign prod_cb   = prod_cb_r;
  assign prod_cr   = prod_cr_r;

endmodule

### src/r2y_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2y_sum
// Adds the products into Y, Cb and Cr; chroma gets the mid-range offset.
// ----------------------------------------------------------------------------
module r2y_sum #(
  parameter int COEF_FRAC_BITS = 22
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [COEF_FRAC_BITS+9:0]         prod_y  [3],
  input  logic [COEF_FRAC_BITS+9:0]         prod_cb [3],
  input  logic [COEF_FRAC_BITS+9:0]         prod_cr [3],
  input  r2y_pkg::mode_t                    mode,
  output logic                              out_valid,
  output logic signed [COEF_FRAC_BITS+11:0] sum_y,
  output logic signed [COEF_FRAC_BITS+11:0] sum_cb,
  output logic signed [COEF_FRAC_BITS+11:0] sum_cr
);
  import r2y_pkg::*;

  localparam int S  = COEF_FRAC_BITS;
  localparam int SW = S + 12;

  // (F + 1) / 2, with S fraction bits
  localparam logic signed [SW-1:0] OFF8  = SW'(64'd256 << (S - 1));
  localparam logic signed [SW-1:0] OFF10 = SW'(64'd1024 << (S - 1));

  function automatic logic signed [SW-1:0] sx(logic [S+9:0] p);
    sx = $signed({2'b00, p});
  endfunction

  logic                 valid_r;
  logic signed [SW-1:0] offset;
  logic signed [SW-1:0] y_r, cb_r, cr_r;
  logic signed [SW-1:0] y_nxt, cb_nxt, cr_nxt;

  always_comb begin
    offset = mode.ten_bit_output ? OFF10 : OFF8;
    y_nxt  = sx(prod_y[0]) + sx(prod_y[1]) + sx(prod_y[2]);
    cb_nxt = sx(prod_cb[0]) - sx(prod_cb[1]) - sx(prod_cb[2]) + offset;
    cr_nxt = sx(prod_cr[0]) - sx(prod_cr[1]) - sx(prod_cr[2]) + offset;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    y_r  <= y_nxt;
    cb_r <= cb_nxt;
    cr_r <= cr_nxt;
  end

  assign out_valid = valid_r;
  assign sum_y     = y_r;
  assign sum_cb    = cb_r;
  assign sum_cr    = cr_r;

endmodule

### src/r2y_clamp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2y_clamp
// Clamps each sum to 0..F, rounds to nearest and drives the result item.
// ----------------------------------------------------------------------------
module r2y_clamp #(
  parameter int COEF_FRAC_BITS = 22
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [COEF_FRAC_BITS+11:0] sum_y,
  input  logic signed [COEF_FRAC_BITS+11:0] sum_cb,
  input  logic signed [COEF_FRAC_BITS+11:0] sum_cr,
  input  r2y_pkg::mode_t                    mode,
  output logic                              out_valid,
  output r2y_pkg::result_t                  out_result
);
  import r2y_pkg::*;

  localparam int S  = COEF_FRAC_BITS;
  localparam int SW = S + 12;
  localparam int CV = S + 10;

  localparam logic signed [SW-1:0] TOP8  = SW'(64'd255 << S);
  localparam logic signed [SW-1:0] TOP10 = SW'(64'd1023 << S);
  localparam logic [CV-1:0]        HALF  = CV'(64'd1 << (S - 1));

  function automatic logic [9:0] clamp_round(logic signed [SW-1:0] v,
                                             logic signed [SW-1:0] top);
    logic [CV-1:0] c;
    logic [CV-1:0] rsum;
    if (v < 0) begin
      c = '0;
    end else if (v > top) begin
      c = top[CV-1:0];
    end else begin
      c = v[CV-1:0];
    end
    rsum = c + HALF;
    clamp_round = rsum[CV-1:S];
  endfunction

  logic                 valid_r;
  logic signed [SW-1:0] top;
  result_t              res_r, res_nxt;

  always_comb begin
    top                 = mode.ten_bit_output ? TOP10 : TOP8;
    res_nxt.luma        = clamp_round(sum_y, top);
    res_nxt.chroma_blue = clamp_round(sum_cb, top);
    res_nxt.chroma_red  = clamp_round(sum_cr, top);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid  = valid_r;
  assign out_result = res_r;

endmodule

### test/r2y_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2y_checker
// Watches the pixel, result and config channels of the converter. It predicts
// each result in fixed point and compares it field by field, in order.
// ----------------------------------------------------------------------------
module r2y_checker #(
  parameter int FRAC = 22
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  r2y_pkg::pixel_t               in_pixel,
  input  logic                          out_strobe,
  input  r2y_pkg::result_t              out_result,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [r2y_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                          cfg_data,
  output int                            fail_count,
  output int                            outstanding
);
  import r2y_pkg::*;

  result_t ycbcr_q[$];
  mode_t   cur_mode;
  int      errs = 0;

  // round(num * 2^FRAC / den), ties up; num and den positive
  function automatic longint fold_coef(longint num, longint den);
    return ((num <<< FRAC) * 2 + den) / (2 * den);
  endfunction

  function automatic logic [9:0] clamp_round(longint acc, longint top);
    if (acc < 0) acc = 0;
    if (acc > top) acc = top;
    return 10'((acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC);
  endfunction

  function automatic result_t predict_ycbcr(pixel_t px, mode_t m);
    longint r, g, b, wr, wb, wg, fs, den_y, den_cb, den_cr, half_f, offs, top;
    result_t res;
    r      = longint'(px.red);
    g      = longint'(px.green);
    b      = longint'(px.blue);
    wr     = m.standard_select ? 2126 : 2990;
    wb     = m.standard_select ? 722 : 1140;
    wg     = 10000 - wr - wb;
    fs     = m.ten_bit_output ? 1023 : 255;
    den_y  = 10000 * 255;
    den_cb = 2 * (10000 - wb) * 255;
    den_cr = 2 * (10000 - wr) * 255;
    half_f = fold_coef(fs, 2 * 255);
    top    = fs <<< FRAC;
    // mid-range offset plus the extra half step
    offs   = (fs + 1) <<< (FRAC - 1);
    res.luma = clamp_round(fold_coef(wr * fs, den_y) * r
                         + fold_coef(wg * fs, den_y) * g
                         + fold_coef(wb * fs, den_y) * b, top);
    res.chroma_blue = clamp_round(half_f * b
                                - fold_coef(wr * fs, den_cb) * r
                                - fold_coef(wg * fs, den_cb) * g + offs, top);
    res.chroma_red = clamp_round(half_f * r
                               - fold_coef(wg * fs, den_cr) * g
                               - fold_coef(wb * fs, den_cr) * b + offs, top);
    return res;
  endfunction

  task automatic check_field(string label, logic [9:0] want, logic [9:0] got);
    if (got !== want) begin
      errs++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      cur_mode.standard_select = 1'b1;
      cur_mode.ten_bit_output  = 1'b1;
      ycbcr_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STANDARD_SELECT: cur_mode.standard_select = cfg_data;
          CFG_TEN_BIT_OUTPUT:  cur_mode.ten_bit_output  = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) ycbcr_q.push_back(predict_ycbcr(in_pixel, cur_mode));
      if (out_strobe) begin
        if (ycbcr_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result: expected none, actual %h", $time, out_result);
        end else begin
          want = ycbcr_q.pop_front();
          check_field("luma", want.luma, out_result.luma);
          check_field("chroma_blue", want.chroma_blue, out_result.chroma_blue);
          check_field("chroma_red", want.chroma_red, out_result.chroma_red);
        end
      end
    end
    outstanding <= ycbcr_q.size();
    fail_count  <= errs;
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixels and mode writes into the RGB to YCbCr converter and gives the
// verdict; result prediction and comparison live in r2y_checker.
// ----------------------------------------------------------------------------
module testbench;
  import r2y_pkg::*;

  localparam int FRAC = 22;
  // idle margin after drain sees no outstanding results
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEMS_PER_PHASE = 124;
  localparam int NUM_PHASES = 10;

  // corner pixels: black, white, primaries, secondaries, mid grays,
  // near-extremes and alternating bit patterns
  localparam logic [23:0] CORNER_RGB [16] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
    24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
    24'h808080, 24'h7F7F7F, 24'h010101, 24'hFEFEFE,
    24'hAA55AA, 24'h55AA55, 24'h0102FE, 24'hFE0201
  };

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  pixel_t               in_pixel;
  logic                 out_strobe;
  result_t              out_result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic                 cfg_data;
  int                   fail_count;
  int                   outstanding;

  // idle_on: sender inserts random gaps; cleared for back-to-back stretches
  bit                   idle_on;
  int                   stretch_left;

  rgb_to_ycbcr_converter_core #(
    .COEF_FRAC_BITS(FRAC)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_pixel   (in_pixel),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  r2y_checker #(
    .FRAC(FRAC)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_pixel    (in_pixel),
    .out_strobe  (out_strobe),
    .out_result  (out_result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Channel value biased toward the rails so clamping gets hit often.
  function automatic logic [7:0] channel_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one item and hold it until the accepting edge. start is left high
  // so a zero-gap follower keeps it up without a low/high pair in one step.
  task automatic send_pixel(input pixel_t px);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (busy);
  endtask

  // Sender stops until every predicted result has come back, then lets the
  // pipe settle. The first edge lets the checker's count catch the last item.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_valid stays high between back-to-back writes; the caller lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Mode change, only called with the pipe empty. Sometimes a write to an
  // unused index is slipped in; the block must ignore it.
  task automatic set_mode(input mode_t m, input bit stray);
    write_reg(CFG_STANDARD_SELECT, m.standard_select);
    if (stray)
      write_reg(CFG_IDX_W'($urandom_range(int'(CFG_TEN_BIT_OUTPUT) + 1,
                                         (1 << CFG_IDX_W) - 1)), 1'($urandom));
    write_reg(CFG_TEN_BIT_OUTPUT, m.ten_bit_output);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    mode_t  m;
    pixel_t px;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_pixel     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = 1'b0;
    idle_on      = 1'b1;
    stretch_left = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners in the reset mode (BT.709, 10-bit).
    foreach (CORNER_RGB[i]) send_pixel(pixel_t'(CORNER_RGB[i]));
    drain();

    // Random phases: the first four walk every mode, incl. both extremes of
    // each register; the rest pick a mode at random.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 4) begin
        m.standard_select = ph[1];
        m.ten_bit_output  = ph[0];
      end else begin
        m.standard_select = 1'($urandom);
        m.ten_bit_output  = 1'($urandom);
      end
      set_mode(m, (ph == 0) || ($urandom_range(0, 1) == 1));

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // alternate stretches with gaps and back-to-back stretches
        if (stretch_left == 0) begin
          idle_on      = ($urandom_range(0, 2) != 0);
          stretch_left = $urandom_range(8, 40);
        end
        stretch_left--;
        px.red   = channel_level();
        px.green = channel_level();
        px.blue  = channel_level();
        send_pixel(px);
        // occasional full stop mid-phase
        if ($urandom_range(0, 99) == 0) drain();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: a correct run takes well under a tenth of this.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
